// File: hdl/hogb_pkg.sv
// Package for the height occupancy grid builder.
// Holds the word types, the cell record, item codes, register map and reset values.
// No dependencies.
`default_nettype none

package hogb_pkg;

  // Item kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Occupancy codes
  localparam logic [7:0] OCC_FREE   = 8'd0;
  localparam logic [7:0] OCC_SPREAD = 8'd100;
  localparam logic [7:0] OCC_MARKED = 8'd254;

  // Register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_OFFSET_X  = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y  = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE = 3'd3;
  localparam logic [2:0] REG_HDIFF     = 3'd4;
  localparam logic [2:0] REG_BAND_LOW  = 3'd5;
  localparam logic [2:0] REG_BAND_HIGH = 3'd6;
  localparam logic [2:0] REG_BORDER    = 3'd7;

  // Reset values
  localparam logic        RST_MODE      = 1'b0;
  localparam logic [15:0] RST_OFFSET_X  = 16'sd0;
  localparam logic [15:0] RST_OFFSET_Y  = -16'sd5000;
  localparam logic [9:0]  RST_CELL_SIZE = 10'd200;
  localparam logic [14:0] RST_HDIFF     = 15'd300;
  localparam logic [15:0] RST_BAND_LOW  = -16'sd300;
  localparam logic [15:0] RST_BAND_HIGH = 16'sd300;
  localparam logic [4:0]  RST_BORDER    = 5'd5;

  // Map size defaults
  localparam int DEF_MAP_COLS = 100;
  localparam int DEF_MAP_ROWS = 50;

  // Divider widths: distance from origin and cell size
  localparam int DIST_W  = 17;
  localparam int CSIZE_W = 10;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [6:0]         cell_col;
    logic [5:0]         cell_row;
  } in_word_t;

  typedef struct packed {
    logic [7:0] occupancy;
    logic       in_map;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] min_h;
    logic signed [15:0] max_h;
    logic               seen;
    logic               marked;
  } cell_t;

endpackage

`default_nettype wire

// File: hdl/hogb_div.sv
// Restoring divider, one quotient bit per cycle, for binning a distance by the cell size.
// Depends on hogb_pkg for default widths.
`default_nettype none

module hogb_div #(
  parameter int NUM_W = hogb_pkg::DIST_W,
  parameter int DEN_W = hogb_pkg::CSIZE_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);
  import hogb_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

// File: hdl/height_occupancy_grid_builder.sv
// Height occupancy grid builder: bins lidar points into a MAP_COLS x MAP_ROWS grid
// kept in one single-port-read, single-port-write memory of cell records, and answers
// cell reads. One item is in work at a time. A point goes through binning, a 17-step
// shared-width divider per axis, one memory read and one write back. A read item for a
// cell in the map makes one memory read, and a clear item writes every cell. After reset
// a clearing pass sweeps all MAP_COLS*MAP_ROWS cells before the first item is taken;
// configuration writes are taken at any time. Every item yields exactly one result word.
// Depends on hogb_pkg and hogb_div.
`default_nettype none

module height_occupancy_grid_builder #(
  parameter int MAP_COLS = hogb_pkg::DEF_MAP_COLS,
  parameter int MAP_ROWS = hogb_pkg::DEF_MAP_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire hogb_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output hogb_pkg::out_word_t       out_word_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import hogb_pkg::*;

  localparam int CELLS = MAP_COLS * MAP_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CMP_W = 12;

  typedef enum logic [2:0] {
    S_IDLE, S_BIN, S_DIV, S_MOD, S_EVAL, S_CLR, S_FIN
  } state_e;

  state_e    state_q;
  in_word_t  item_q;
  out_word_t res_q, out_q;
  logic      out_valid_q;
  logic      clr_item_q;
  logic [AW-1:0] clr_cnt_q, addr_q;

  // Configuration registers
  logic              mode_q;
  logic signed [15:0] off_x_q, off_y_q, band_lo_q, band_hi_q;
  logic [9:0]        csize_q;
  logic [14:0]       hdiff_q;
  logic [4:0]        border_q;

  // Memory
  cell_t   mem [CELLS];
  cell_t   rdata_q;
  logic    rd_en, mem_we;
  logic [AW-1:0] raddr, waddr;
  cell_t   wdata;

  // Binning
  logic signed [DIST_W-1:0] dx, dy;
  logic         bin_ok, div_start;
  logic [CSIZE_W-1:0] den;
  logic [DIST_W-1:0]  qx, qy;
  logic         divx_done, divy_done;
  logic         q_ok;
  logic [AW-1:0] pt_addr, rd_addr;
  logic         rd_in_range;

  // Update and evaluation
  cell_t        upd;
  logic         out_band;
  logic [CMP_W-1:0] col_w, row_w, b_w;
  logic signed [16:0] spread;
  logic         inner;
  logic [7:0]   occ;
  logic         out_free;

  // APB write and read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_MODE;
      off_x_q   <= RST_OFFSET_X;
      off_y_q   <= RST_OFFSET_Y;
      csize_q   <= RST_CELL_SIZE;
      hdiff_q   <= RST_HDIFF;
      band_lo_q <= RST_BAND_LOW;
      band_hi_q <= RST_BAND_HIGH;
      border_q  <= RST_BORDER;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_MODE:      mode_q    <= pwdata[0];
        REG_OFFSET_X:  off_x_q   <= pwdata[15:0];
        REG_OFFSET_Y:  off_y_q   <= pwdata[15:0];
        REG_CELL_SIZE: csize_q   <= pwdata[9:0];
        REG_HDIFF:     hdiff_q   <= pwdata[14:0];
        REG_BAND_LOW:  band_lo_q <= pwdata[15:0];
        REG_BAND_HIGH: band_hi_q <= pwdata[15:0];
        REG_BORDER:    border_q  <= pwdata[4:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:      prdata = {31'd0, mode_q};
      REG_OFFSET_X:  prdata = {{16{off_x_q[15]}}, off_x_q};
      REG_OFFSET_Y:  prdata = {{16{off_y_q[15]}}, off_y_q};
      REG_CELL_SIZE: prdata = {22'd0, csize_q};
      REG_HDIFF:     prdata = {17'd0, hdiff_q};
      REG_BAND_LOW:  prdata = {{16{band_lo_q[15]}}, band_lo_q};
      REG_BAND_HIGH: prdata = {{16{band_hi_q[15]}}, band_hi_q};
      REG_BORDER:    prdata = {27'd0, border_q};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Distance from the map origin; a point on or before the origin is outside
  always_comb begin
    dx     = DIST_W'(item_q.point_x) - DIST_W'(off_x_q);
    dy     = DIST_W'(item_q.point_y) - DIST_W'(off_y_q);
    bin_ok = (dx > 0) && (dy > 0);
    den    = (csize_q == '0) ? CSIZE_W'(1) : csize_q;
    div_start = (state_q == S_BIN) && (item_q.kind == KIND_POINT) && bin_ok;
  end

  hogb_div #(.NUM_W(DIST_W), .DEN_W(CSIZE_W)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dx), .den_i(den),
    .done_o(divx_done), .quot_o(qx)
  );

  hogb_div #(.NUM_W(DIST_W), .DEN_W(CSIZE_W)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dy), .den_i(den),
    .done_o(divy_done), .quot_o(qy)
  );

  // Cell addresses
  always_comb begin
    q_ok        = (qx < DIST_W'(MAP_COLS)) && (qy < DIST_W'(MAP_ROWS));
    pt_addr     = AW'(qy) * AW'(MAP_COLS) + AW'(qx);
    rd_in_range = (CMP_W'(item_q.cell_col) < CMP_W'(MAP_COLS)) &&
                  (CMP_W'(item_q.cell_row) < CMP_W'(MAP_ROWS));
    rd_addr     = AW'(item_q.cell_row) * AW'(MAP_COLS) + AW'(item_q.cell_col);
  end

  // Memory port control
  always_comb begin
    rd_en = 1'b0;
    raddr = pt_addr;
    if (state_q == S_DIV && divx_done && q_ok) begin
      rd_en = 1'b1;
    end else if (state_q == S_BIN && item_q.kind == KIND_READ && rd_in_range) begin
      rd_en = 1'b1;
      raddr = rd_addr;
    end
    mem_we = (state_q == S_CLR) || (state_q == S_MOD);
    waddr  = (state_q == S_CLR) ? clr_cnt_q : addr_q;
    wdata  = (state_q == S_CLR) ? '0 : upd;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Fold the point's height into the cell record
  always_comb begin
    out_band     = !((item_q.point_z > band_lo_q) && (item_q.point_z < band_hi_q));
    upd.seen     = 1'b1;
    upd.marked   = rdata_q.marked | out_band;
    upd.min_h    = (!rdata_q.seen || item_q.point_z < rdata_q.min_h) ?
                   item_q.point_z : rdata_q.min_h;
    upd.max_h    = (!rdata_q.seen || item_q.point_z > rdata_q.max_h) ?
                   item_q.point_z : rdata_q.max_h;
  end

  // Occupancy of the cell just read
  always_comb begin
    col_w  = CMP_W'(item_q.cell_col);
    row_w  = CMP_W'(item_q.cell_row);
    b_w    = CMP_W'(border_q);
    inner  = (col_w >= b_w) && (col_w + b_w < CMP_W'(MAP_COLS)) &&
             (row_w >= b_w) && (row_w + b_w < CMP_W'(MAP_ROWS));
    spread = 17'(rdata_q.max_h) - 17'(rdata_q.min_h);
    occ    = OCC_FREE;
    if (mode_q) begin
      if (rdata_q.marked) occ = OCC_MARKED;
    end else if (inner && rdata_q.seen && (spread > $signed({2'b00, hdiff_q}))) begin
      occ = OCC_SPREAD;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer, result register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      addr_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_word_i;
            state_q <= S_BIN;
          end
        end
        S_BIN: begin
          res_q <= '0;
          if (item_q.kind == KIND_POINT) begin
            state_q <= bin_ok ? S_DIV : S_FIN;
          end else if (item_q.kind == KIND_READ) begin
            state_q <= rd_in_range ? S_EVAL : S_FIN;
          end else if (item_q.kind == KIND_CLEAR) begin
            clr_cnt_q  <= '0;
            clr_item_q <= 1'b1;
            state_q    <= S_CLR;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          if (divx_done) begin
            addr_q  <= pt_addr;
            state_q <= q_ok ? S_MOD : S_FIN;
          end
        end
        S_MOD: begin
          res_q.in_map <= 1'b1;
          state_q      <= S_FIN;
        end
        S_EVAL: begin
          res_q.occupancy <= occ;
          state_q         <= S_FIN;
        end
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(CELLS - 1)) begin
            clr_item_q <= 1'b0;
            if (clr_item_q) begin
              res_q   <= '0;
              state_q <= S_FIN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Both axis dividers run in lockstep and finish only while waiting on them
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (divx_done == divy_done) && (!divx_done || state_q == S_DIV))
    else $error("divider done out of step");

  // A finished result moves to the output once the output slot is free
  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("result not delivered");

  // The memory is never written while idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE))
    else $error("memory written while idle");

  // A result never carries both an occupancy and a point flag
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.in_map && out_word_o.occupancy != OCC_FREE))
    else $error("mixed result word");

endmodule

`default_nettype wire
